// File: rtl/pressure_temperature_compensation_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pressure/temperature compensation block
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH

// same-cycle implication
`define PTC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants of the pressure/temperature compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

   localparam int DIV_STAGES = 32;
   localparam int FIFO_DEPTH = 2;

   localparam logic signed [26:0] OFFSET_FINE = 27'sd64000;
   localparam logic signed [36:0] DIV_BASE    = 37'sd32768;
   localparam logic signed [22:0] PRESS_FULL  = 23'sd1048576;
   localparam logic [31:0]        PRESS_SCALE = 32'd3125;
   localparam logic [31:0]        HALF_RANGE  = 32'h8000_0000;
   localparam logic signed [34:0] ROUND_HALF  = 35'sd128;

   typedef enum logic [1:0] {
      CSR_TEMP_CAL   = 2'd0,
      CSR_PRESS_LOW  = 2'd1,
      CSR_PRESS_MID  = 2'd2,
      CSR_PRESS_HIGH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } calib_type;

   // fields carried alongside the divider
   typedef struct packed {
      logic signed [31:0] centi;
      logic signed [31:0] fine;
      logic               invalid;
      logic               big;
   } side_type;

endpackage

`default_nettype wire

// File: rtl/pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Barometric temperature and pressure compensation, 32-bit integer scheme.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one transaction per raw sample pair; tdata bits 19:0 raw_temp,
//           bits 39:20 raw_press.
//   rsp_* : one transaction per sample pair, in order; tdata bits 31:0
//           temp_centi, 63:32 fine_temp, 95:64 press_pa; tuser is
//           press_invalid (divisor zero, pressure forced to 0).
//   csr_* : write port for the four calibration registers, written while
//           no transaction is in flight.
//   From accept to rsp_tvalid a result passes 3 temperature stages,
//   5 divisor/dividend stages, a 32-stage divider, 3 correction stages and
//   the output buffer. Throughput is one transaction per cycle, kept by the
//   one-bit-per-stage divider pipeline, while the pipeline is not held.
//   A two-entry output buffer takes results while the receiver stalls; once
//   it is full and rsp_tready is low, the whole pipeline holds and
//   req_tready drops. Synchronous reset empties the pipeline and clears the
//   calibration registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pressure_temperature_compensation_assert.svh"

module pressure_temperature_compensation import ptc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // raw_temp, raw_press
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // temp_centi, fine_temp, press_pa
   output logic [0:0]  rsp_tuser,   // press_invalid
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [63:0] csr_wdata
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam logic [PTR_W:0] CNT_FULL = (PTR_W + 1)'(FIFO_DEPTH);

   typedef struct packed {
      logic [31:0] centi;
      logic [31:0] fine;
      logic [31:0] press;
      logic        invalid;
   } result_type;

   logic [47:0] temp_cal_ff;
   logic [63:0] press_low_ff;
   logic [63:0] press_mid_ff;
   logic [15:0] press_high_ff;
   calib_type   calib;

   logic               advance;
   logic               t_valid;
   logic signed [31:0] t_fine;
   logic [19:0]        t_raw_press;
   logic               d_in_valid;
   logic [31:0]        d_dividend;
   logic [31:0]        d_divisor;
   side_type           d_in_side;
   logic               d_out_valid;
   logic [31:0]        d_quotient;
   side_type           d_out_side;
   logic               r_valid;
   logic signed [31:0] r_centi;
   logic signed [31:0] r_fine;
   logic [31:0]        r_press;
   logic               r_invalid;

   result_type       fifo_mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   fifo_cnt_ff;
   logic             push;
   logic             pop;
   result_type       head;

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff   <= '0;
         press_low_ff  <= '0;
         press_mid_ff  <= '0;
         press_high_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_TEMP_CAL:   temp_cal_ff   <= csr_wdata[47:0];
            CSR_PRESS_LOW:  press_low_ff  <= csr_wdata;
            CSR_PRESS_MID:  press_mid_ff  <= csr_wdata;
            CSR_PRESS_HIGH: press_high_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign calib.t1 = temp_cal_ff[15:0];
   assign calib.t2 = temp_cal_ff[31:16];
   assign calib.t3 = temp_cal_ff[47:32];
   assign calib.p1 = press_low_ff[15:0];
   assign calib.p2 = press_low_ff[31:16];
   assign calib.p3 = press_low_ff[47:32];
   assign calib.p4 = press_low_ff[63:48];
   assign calib.p5 = press_mid_ff[15:0];
   assign calib.p6 = press_mid_ff[31:16];
   assign calib.p7 = press_mid_ff[47:32];
   assign calib.p8 = press_mid_ff[63:48];
   assign calib.p9 = press_high_ff;

   // whole pipeline moves whenever the output buffer can take a result
   assign advance    = (fifo_cnt_ff != CNT_FULL) || rsp_tready;
   assign req_tready = advance;

   ptc_temp u_temp (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .calib         (calib),
      .in_valid      (req_tvalid),
      .raw_temp      (req_tdata[19:0]),
      .raw_press     (req_tdata[39:20]),
      .out_valid     (t_valid),
      .fine_temp     (t_fine),
      .raw_press_out (t_raw_press)
   );

   ptc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .calib     (calib),
      .in_valid  (t_valid),
      .fine_temp (t_fine),
      .raw_press (t_raw_press),
      .out_valid (d_in_valid),
      .dividend  (d_dividend),
      .divisor   (d_divisor),
      .side      (d_in_side)
   );

   ptc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (d_in_valid),
      .dividend  (d_dividend),
      .divisor   (d_divisor),
      .in_side   (d_in_side),
      .out_valid (d_out_valid),
      .quotient  (d_quotient),
      .out_side  (d_out_side)
   );

   ptc_post u_post (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .calib         (calib),
      .in_valid      (d_out_valid),
      .quotient      (d_quotient),
      .in_side       (d_out_side),
      .out_valid     (r_valid),
      .temp_centi    (r_centi),
      .fine_temp     (r_fine),
      .press_pa      (r_press),
      .press_invalid (r_invalid)
   );

   // output buffer
   assign push = r_valid && advance;
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            fifo_cnt_ff <= fifo_cnt_ff + 1'b1;
         end else if (pop && !push) begin
            fifo_cnt_ff <= fifo_cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= '{centi: r_centi, fine: r_fine, press: r_press,
                                  invalid: r_invalid};
      end
   end

   assign head         = fifo_mem[rd_ptr_ff];
   assign rsp_tvalid   = (fifo_cnt_ff != '0);
   assign rsp_tdata    = {head.press, head.fine, head.centi};
   assign rsp_tuser[0] = head.invalid;

   `PTC_ASSERT_NOW(a_invalid_zero, rsp_tvalid && rsp_tuser[0], rsp_tdata[95:64] == 32'd0, "invalid pressure transaction carries nonzero pressure")
   `PTC_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_cnt_ff <= CNT_FULL, "output buffer count out of range")
   `PTC_ASSERT_NEXT(a_p9_write, csr_we && (csr_addr == CSR_PRESS_HIGH), calib.p9 == $past(csr_wdata[15:0]), "P9 write not taken")

endmodule

`default_nettype wire

// File: rtl/ptc_temp.sv
// ----------------------------------------------------------------------------
// ptc_temp
// Three-stage fine temperature pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_temp import ptc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  calib_type          calib,
   input  logic               in_valid,
   input  logic [19:0]        raw_temp,
   input  logic [19:0]        raw_press,
   output logic               out_valid,
   output logic signed [31:0] fine_temp,
   output logic [19:0]        raw_press_out
);

   logic signed [17:0] x1;
   logic signed [16:0] d;
   logic signed [33:0] a_prod_in;
   logic signed [33:0] dd_full;
   logic signed [22:0] a_in;
   logic signed [36:0] b_prod_in;
   logic signed [31:0] fine_in;

   logic               v1_ff, v2_ff, v3_ff;
   logic signed [33:0] a_prod_ff;
   logic [31:0]        dd_ff;
   logic [19:0]        rp1_ff, rp2_ff, rp3_ff;
   logic signed [22:0] a_ff;
   logic signed [36:0] b_prod_ff;
   logic signed [31:0] fine_ff;

   assign x1        = $signed({1'b0, raw_temp[19:3]}) - $signed({1'b0, calib.t1, 1'b0});
   assign a_prod_in = 34'(x1) * 34'(calib.t2);
   assign d         = $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, calib.t1});
   assign dd_full   = 34'(d) * 34'(d);

   assign a_in      = 23'(a_prod_ff >>> 11);
   assign b_prod_in = 37'($signed({1'b0, dd_ff[31:12]})) * 37'(calib.t3);

   assign fine_in   = 32'(a_ff) + 32'(b_prod_ff >>> 14);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_prod_ff <= a_prod_in;
         dd_ff     <= dd_full[31:0];
         rp1_ff    <= raw_press;
         a_ff      <= a_in;
         b_prod_ff <= b_prod_in;
         rp2_ff    <= rp1_ff;
         fine_ff   <= fine_in;
         rp3_ff    <= rp2_ff;
      end
   end

   assign out_valid     = v3_ff;
   assign fine_temp     = fine_ff;
   assign raw_press_out = rp3_ff;

endmodule

`default_nettype wire

// File: rtl/ptc_prep.sv
// ----------------------------------------------------------------------------
// ptc_prep
// Five-stage pipeline: temperature in centidegrees, divisor and dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_prep import ptc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  calib_type          calib,
   input  logic               in_valid,
   input  logic signed [31:0] fine_temp,
   input  logic [19:0]        raw_press,
   output logic               out_valid,
   output logic [31:0]        dividend,
   output logic [31:0]        divisor,
   output side_type           side
);

   logic signed [26:0] v1_in;
   logic signed [26:0] q;
   logic signed [49:0] qq_full;
   logic signed [31:0] centi_in;
   logic signed [55:0] v2a_in;
   logic signed [43:0] v2b_in;
   logic signed [53:0] v1a_in;
   logic signed [42:0] v1b_in;
   logic signed [57:0] v2_in;
   logic signed [35:0] v1c_in;
   logic signed [53:0] dprod_in;
   logic [31:0]        num_in;
   logic [31:0]        dsr_in;
   logic [31:0]        pm;
   logic               big;

   logic [4:0]         vld_ff;
   logic signed [26:0] v1_ff;
   logic [49:0]        qq_ff;
   logic signed [31:0] fine_ff [5];
   logic signed [31:0] centi_ff [5];
   logic [19:0]        rp_ff [3];
   logic signed [55:0] v2a_ff;
   logic signed [43:0] v2b_ff;
   logic signed [53:0] v1a_ff;
   logic signed [42:0] v1b_ff;
   logic signed [57:0] v2_ff;
   logic signed [35:0] v1c_ff;
   logic signed [53:0] dprod_ff;
   logic [31:0]        num_ff;
   logic [31:0]        dvd_ff;
   logic [31:0]        dsr_ff;
   logic               invalid_ff;
   logic               big_ff;

   // stage 4
   assign v1_in    = 27'(fine_temp >>> 1) - OFFSET_FINE;
   assign q        = v1_in >>> 2;
   assign qq_full  = 50'(q) * 50'(q);
   assign centi_in = 32'((35'(fine_temp) + (35'(fine_temp) <<< 2) + ROUND_HALF) >>> 8);

   // stage 5
   assign v2a_in = 56'($signed({1'b0, qq_ff[49:11]})) * 56'(calib.p6);
   assign v2b_in = 44'(v1_ff) * 44'(calib.p5);
   assign v1a_in = 54'($signed({1'b0, qq_ff[49:13]})) * 54'(calib.p3);
   assign v1b_in = 43'(v1_ff) * 43'(calib.p2);

   // stage 6
   assign v2_in  = ((58'(v2a_ff) + (58'(v2b_ff) <<< 1)) >>> 2) + (58'(calib.p4) <<< 16);
   assign v1c_in = 36'(((55'(v1a_ff) >>> 3) + (55'(v1b_ff) >>> 1)) >>> 18);

   // stage 7
   assign dprod_in = 54'(37'(v1c_ff) + DIV_BASE) * 54'($signed({1'b0, calib.p1}));
   assign num_in   = 32'(58'(PRESS_FULL - 23'($signed({1'b0, rp_ff[2]}))) - (v2_ff >>> 12));

   // stage 8: large dividends are divided first and doubled afterwards
   assign dsr_in = dprod_ff[46:15];
   assign pm     = num_ff * PRESS_SCALE;
   assign big    = (pm >= HALF_RANGE);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         v1_ff       <= v1_in;
         qq_ff       <= qq_full[49:0];
         fine_ff[0]  <= fine_temp;
         centi_ff[0] <= centi_in;
         rp_ff[0]    <= raw_press;
         for (int i = 1; i < 5; i++) begin
            fine_ff[i]  <= fine_ff[i-1];
            centi_ff[i] <= centi_ff[i-1];
         end
         rp_ff[1]   <= rp_ff[0];
         rp_ff[2]   <= rp_ff[1];
         v2a_ff     <= v2a_in;
         v2b_ff     <= v2b_in;
         v1a_ff     <= v1a_in;
         v1b_ff     <= v1b_in;
         v2_ff      <= v2_in;
         v1c_ff     <= v1c_in;
         dprod_ff   <= dprod_in;
         num_ff     <= num_in;
         dvd_ff     <= big ? pm : {pm[30:0], 1'b0};
         dsr_ff     <= dsr_in;
         invalid_ff <= (dsr_in == 32'd0);
         big_ff     <= big;
      end
   end

   assign out_valid    = vld_ff[4];
   assign dividend     = dvd_ff;
   assign divisor      = dsr_ff;
   assign side.centi   = centi_ff[4];
   assign side.fine    = fine_ff[4];
   assign side.invalid = invalid_ff;
   assign side.big     = big_ff;

endmodule

`default_nettype wire

// File: rtl/ptc_divider.sv
// ----------------------------------------------------------------------------
// ptc_divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_divider import ptc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [31:0] quotient,
   output side_type    out_side
);

   logic        vld_ff  [DIV_STAGES];
   logic [31:0] rem_ff  [DIV_STAGES];
   logic [31:0] dvd_ff  [DIV_STAGES];
   logic [31:0] dsr_ff  [DIV_STAGES];
   side_type    side_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic        v_i;
      logic [31:0] rem_i;
      logic [31:0] dvd_i;
      logic [31:0] dsr_i;
      side_type    side_i;
      logic [32:0] shifted;
      logic        ge;
      logic [32:0] diff;

      if (k == 0) begin : g_first
         assign v_i    = in_valid;
         assign rem_i  = '0;
         assign dvd_i  = dividend;
         assign dsr_i  = divisor;
         assign side_i = in_side;
      end else begin : g_next
         assign v_i    = vld_ff[k-1];
         assign rem_i  = rem_ff[k-1];
         assign dvd_i  = dvd_ff[k-1];
         assign dsr_i  = dsr_ff[k-1];
         assign side_i = side_ff[k-1];
      end

      assign shifted = {rem_i, dvd_i[31]};
      assign ge      = (shifted >= {1'b0, dsr_i});
      assign diff    = shifted - {1'b0, dsr_i};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= v_i;
         end
      end

      // dividend word shifts out on top, quotient bits fill from below
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= ge ? diff[31:0] : shifted[31:0];
            dvd_ff[k]  <= {dvd_i[30:0], ge};
            dsr_ff[k]  <= dsr_i;
            side_ff[k] <= side_i;
         end
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign quotient  = dvd_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/ptc_post.sv
// ----------------------------------------------------------------------------
// ptc_post
// Three-stage second-order pressure correction.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_post import ptc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  calib_type          calib,
   input  logic               in_valid,
   input  logic [31:0]        quotient,
   input  side_type           in_side,
   output logic               out_valid,
   output logic signed [31:0] temp_centi,
   output logic signed [31:0] fine_temp,
   output logic [31:0]        press_pa,
   output logic               press_invalid
);

   logic [31:0]        p;
   logic [31:0]        s32;
   logic [31:0]        sq_in;
   logic signed [46:0] c2p_in;
   logic signed [36:0] c1p_in;
   logic signed [33:0] c2_in;
   logic signed [36:0] corr;
   logic [31:0]        press_in;

   logic [2:0]         vld_ff;
   logic [31:0]        p1_ff, p2_ff;
   logic [31:0]        sq_ff;
   logic signed [46:0] c2p_ff;
   logic signed [36:0] c1p_ff;
   logic signed [33:0] c2_ff;
   side_type           side1_ff, side2_ff;
   logic signed [31:0] centi_ff, fine_ff;
   logic [31:0]        press_ff;
   logic               invalid_ff;

   assign p      = in_side.big ? {quotient[30:0], 1'b0} : quotient;
   assign s32    = {3'b000, p[31:3]};
   assign sq_in  = s32 * s32;
   assign c2p_in = 47'($signed({1'b0, p[31:2]})) * 47'(calib.p8);

   assign c1p_in = 37'($signed({1'b0, sq_ff[31:13]})) * 37'(calib.p9);
   assign c2_in  = 34'(c2p_ff >>> 13);

   assign corr     = (37'(c1p_ff >>> 12) + 37'(c2_ff) + 37'(calib.p7)) >>> 4;
   assign press_in = side2_ff.invalid ? 32'd0 : p2_ff + 32'(corr);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ff      <= p;
         sq_ff      <= sq_in;
         c2p_ff     <= c2p_in;
         side1_ff   <= in_side;
         p2_ff      <= p1_ff;
         c1p_ff     <= c1p_in;
         c2_ff      <= c2_in;
         side2_ff   <= side1_ff;
         centi_ff   <= side2_ff.centi;
         fine_ff    <= side2_ff.fine;
         press_ff   <= press_in;
         invalid_ff <= side2_ff.invalid;
      end
   end

   assign out_valid     = vld_ff[2];
   assign temp_centi    = centi_ff;
   assign fine_temp     = fine_ff;
   assign press_pa      = press_ff;
   assign press_invalid = invalid_ff;

endmodule

`default_nettype wire

// File: verif/pressure_temperature_compensation_tb.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_tb
// Drives raw temperature/pressure pairs through the compensation block under
// several calibration sets and handshake idling patterns, predicts each
// compensated result in the testbench and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_temperature_compensation_tb;
   import ptc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 44;
   localparam int CYCLE_CAP = 400000;

   typedef struct packed {
      logic [31:0] centi;
      logic [31:0] fine;
      logic [31:0] press;
      logic        invalid;
   } compensated_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [63:0] csr_wdata;

   // calibration shadow
   logic [47:0] cal_temp;
   logic [63:0] cal_low;
   logic [63:0] cal_mid;
   logic [15:0] cal_high;

   compensated_type pending_results[$];
   int unsigned     mismatches;
   int unsigned     cycles;
   int unsigned     send_idle_pct;
   int unsigned     recv_stall_pct;
   int unsigned     hold_off_cycles;

   pressure_temperature_compensation uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint asr(longint x, int n);
      return x >>> n;
   endfunction

   function automatic longint sword(logic [63:0] r, int k);
      logic signed [15:0] w;
      w = r[16*k +: 16];
      return longint'(w);
   endfunction

   function automatic compensated_type compensate(logic [19:0] raw_t, logic [19:0] raw_p);
      compensated_type res;
      longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint a, d, b, fine, v1, q, v2, num, c1, c2, corr;
      logic signed [31:0] fine32;
      logic [31:0] divisor, p, s, sq;
      t1 = longint'(cal_temp[15:0]);
      t2 = sword(64'(cal_temp), 1);
      t3 = sword(64'(cal_temp), 2);
      p1 = longint'(cal_low[15:0]);
      p2 = sword(cal_low, 1);
      p3 = sword(cal_low, 2);
      p4 = sword(cal_low, 3);
      p5 = sword(cal_mid, 0);
      p6 = sword(cal_mid, 1);
      p7 = sword(cal_mid, 2);
      p8 = sword(cal_mid, 3);
      p9 = sword(64'(cal_high), 0);
      a = asr(((longint'(raw_t) >>> 3) - t1 * 2) * t2, 11);
      d = (longint'(raw_t) >>> 4) - t1;
      b = asr(((d * d) >>> 12) * t3, 14);
      fine32 = 32'(a + b);
      fine = longint'(fine32);
      res.fine = fine32;
      res.centi = 32'(asr(fine * 5 + 128, 8));
      v1 = asr(fine, 1) - 64000;
      q = asr(v1, 2);
      v2 = asr(q * q, 11) * p6;
      v2 = v2 + v1 * p5 * 2;
      v2 = asr(v2, 2) + p4 * 65536;
      v1 = asr(asr(p3 * asr(q * q, 13), 3) + asr(p2 * v1, 1), 18);
      v1 = asr((32768 + v1) * p1, 15);
      divisor = v1[31:0];
      res.press = '0;
      res.invalid = 1'b0;
      if (divisor == 0) begin
         res.invalid = 1'b1;
      end else begin
         num = (1048576 - longint'(raw_p)) - asr(v2, 12);
         p = 32'(num * 3125);
         if (p < HALF_RANGE) p = (p << 1) / divisor;
         else p = (p / divisor) * 2;
         s = p >> 3;
         sq = s * s;
         c1 = asr(p9 * longint'(sq >> 13), 12);
         c2 = asr(longint'(p >> 2) * p8, 13);
         corr = asr(c1 + c2 + p7, 4);
         res.press = 32'(longint'(p) + corr);
      end
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", field, got, want);
      mismatches++;
   endtask

   // result checker
   always @(posedge clock) begin
      compensated_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata[31:0], 32'h0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[31:0] !== want.centi)
               report_mismatch("temp_centi", rsp_tdata[31:0], want.centi);
            if (rsp_tdata[63:32] !== want.fine)
               report_mismatch("fine_temp", rsp_tdata[63:32], want.fine);
            if (rsp_tdata[95:64] !== want.press)
               report_mismatch("press_pa", rsp_tdata[95:64], want.press);
            if (rsp_tuser[0] !== want.invalid)
               report_mismatch("press_invalid", 32'(rsp_tuser), 32'(want.invalid));
         end
      end
   end

   // receiver stalls, with a counted hold-off stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // leaves req_tvalid high after the handshake; callers drop it when they pause
   task automatic send_pair(logic [19:0] raw_t, logic [19:0] raw_p);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {raw_p, raw_t};
      pending_results.push_back(compensate(raw_t, raw_p));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [63:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_TEMP_CAL:  cal_temp = value[47:0];
         CSR_PRESS_LOW: cal_low  = value;
         CSR_PRESS_MID: cal_mid  = value;
         default:       cal_high = value[15:0];
      endcase
   endtask

   task automatic load_calibration(logic [63:0] t, logic [63:0] lo, logic [63:0] mid,
                                   logic [63:0] hi);
      drain();
      write_csr(CSR_TEMP_CAL, t);
      write_csr(CSR_PRESS_LOW, lo);
      write_csr(CSR_PRESS_MID, mid);
      write_csr(CSR_PRESS_HIGH, hi);
      csr_we <= 1'b0;
   endtask

   // typical sensor calibration
   task automatic load_typical();
      load_calibration({16'hFE0C, 16'h6882, 16'h6E7A},
                       {16'h0B5E, 16'h0BCE, 16'hD6F8, 16'h9530},
                       {16'h1770, 16'hBFE0, 16'hFFF9, 16'h008C},
                       64'hFFFFFFFFFFFF0F2E);
   endtask

   task automatic test_reset_zero_divisor();
      // all registers zero: divisor is zero, pressure forced to 0
      send_pair(20'h0, 20'h0);
      send_pair(20'hFFFFF, 20'hFFFFF);
      send_pair(20'h80000, 20'h7FFFF);
   endtask

   task automatic test_directed();
      logic [19:0] corners[5] = '{20'h0, 20'hFFFFF, 20'h80000, 20'h7FFFF, 20'h82000};
      load_typical();
      foreach (corners[i]) send_pair(corners[i], corners[4 - i]);
      send_pair(20'h7E6D8, 20'h65680);
      // extreme calibration words
      load_calibration(64'hFFFF_FFFF_FFFF, 64'h7FFF_8000_7FFF_FFFF, 64'h8000_7FFF_8000_7FFF,
                       64'h8000);
      foreach (corners[i]) send_pair(corners[i], corners[i]);
      load_calibration(64'h8000_7FFF_0000, 64'h8000_7FFF_8000_0001, 64'h7FFF_8000_7FFF_8000,
                       64'h7FFF);
      foreach (corners[i]) send_pair(corners[i], corners[(i + 2) % 5]);
      // small P1 with wide dividend: large-dividend path
      load_calibration({16'h0000, 16'h0001, 16'h0000}, 64'h0000_0000_0000_0001, 64'h0, 64'h0);
      send_pair(20'h0, 20'h0);
      send_pair(20'hFFFFF, 20'h0);
   endtask

   task automatic random_phase(int unsigned n, int unsigned idle, int unsigned stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (n) begin
         if ($urandom_range(3) == 0) send_pair(20'($urandom), 20'($urandom));
         else send_pair(20'($urandom_range(20'h90000, 20'h70000)),
                        20'($urandom_range(20'h70000, 20'h40000)));
      end
   endtask

   task automatic test_random();
      load_typical();
      random_phase(90, 0, 0);
      random_phase(90, 48, 0);
      load_calibration({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       64'($urandom));
      random_phase(90, 0, 48);
      // near-typical calibration with random low bits
      load_calibration({16'hFE0C ^ 16'($urandom_range(255)), 16'h6882, 16'h6E7A},
                       {16'h0B5E, 16'h0BCE, 16'hD6F8, 16'h9530 ^ 16'($urandom_range(4095))},
                       {16'h1770, 16'hBFE0, 16'hFFF9, 16'h008C}, 64'hFFFFFFFFFFFF0F2E);
      random_phase(90, 16, 16);
      random_phase(40, 0, 0);
   endtask

   task automatic test_backpressure();
      req_tvalid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles <= 200;
      @(posedge clock);
      repeat (60) send_pair(20'($urandom), 20'($urandom));
      // pause until every result is in
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) send_pair(20'($urandom), 20'($urandom));
      // back to the reset calibration: zero divisor again
      load_calibration(64'h0, 64'h0, 64'h0, 64'h0);
      send_pair(20'h12345, 20'h6789A);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = CSR_TEMP_CAL;
      csr_wdata = '0;
      cal_temp = '0;
      cal_low = '0;
      cal_mid = '0;
      cal_high = '0;
      mismatches = 0;
      cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_zero_divisor();
      test_directed();
      test_random();
      test_backpressure();
      drain();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/ptc_pkg.sv
rtl/ptc_temp.sv
rtl/ptc_prep.sv
rtl/ptc_divider.sv
rtl/ptc_post.sv
rtl/pressure_temperature_compensation.sv
verif/pressure_temperature_compensation_tb.sv
